FILE: hdl/p12d_pkg.sv
// Shared types and constants for the packed 12-bit sample deinterleaver.
// Used by the front, queue, back and top-level modules; depends on nothing.
package p12d_pkg;

  localparam int MAX_CHANNELS = 16;
  localparam int CH_W         = $clog2(MAX_CHANNELS);
  localparam int CNT_CFG_W    = 5;
  localparam int TOTAL_W      = 32;
  localparam int FRAME_W      = 32;
  localparam int SAMPLE_W     = 12;
  localparam int SUM_W        = 16;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 32;
  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);

  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_SAMPLES = 2'd1;

  typedef enum logic [2:0] {
    PH_LOW  = 3'b001,
    PH_MID  = 3'b010,
    PH_HIGH = 3'b100
  } phase_t;

  typedef struct packed {
    logic                clr;
    logic [SAMPLE_W-1:0] raw;
    logic [CH_W-1:0]     ch;
    logic [FRAME_W-1:0]  frame;
    logic                last;
    logic                partial;
  } item_t;

endpackage

FILE: hdl/p12d_front.sv
// Front end: configuration registers, byte assembly and sample classification.
// Assigns channel, frame and last flags, and pushes one item per sample.
// Depends on p12d_pkg.
module p12d_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [p12d_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [p12d_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                             accept,
  input  logic                             start_record,
  input  logic [7:0]                       byte_in,
  output logic                             push,
  output p12d_pkg::item_t                  item
);
  import p12d_pkg::*;

  logic [CNT_CFG_W-1:0] chan_cnt_r;
  logic [TOTAL_W-1:0]   total_r;
  phase_t               phase_r, phase_nxt, phase_eff;
  logic [7:0]           lo_r, lo_nxt, mid_r, mid_nxt;
  logic [TOTAL_W-1:0]   cnt_r, cnt_nxt, cnt_eff;
  logic [CH_W-1:0]      ch_r, ch_nxt, ch_eff, ch_use;
  logic [FRAME_W-1:0]   frame_r, frame_nxt, frame_eff, frame_use;
  logic                 clr_pend_r, clr_pend_nxt;
  logic [CNT_CFG_W-1:0] n_eff;
  logic [CH_W:0]        ch_inc;
  logic                 pre_wrap, post_wrap, want, last;
  logic [SAMPLE_W-1:0]  raw;

  always_comb begin
    if (chan_cnt_r == '0) begin
      n_eff = CNT_CFG_W'(1);
    end else if (chan_cnt_r > CNT_CFG_W'(MAX_CHANNELS)) begin
      n_eff = CNT_CFG_W'(MAX_CHANNELS);
    end else begin
      n_eff = chan_cnt_r;
    end
  end

  always_comb begin
    phase_eff = start_record ? PH_LOW : phase_r;
    cnt_eff   = start_record ? '0 : cnt_r;
    ch_eff    = start_record ? '0 : ch_r;
    frame_eff = start_record ? '0 : frame_r;

    raw = '0;
    unique case (phase_eff)
      PH_LOW:  raw = '0;
      PH_MID:  raw = {byte_in[3:0], lo_r};
      PH_HIGH: raw = {mid_r[7:4], byte_in};
      default: raw = '0;
    endcase

    want      = (phase_eff != PH_LOW) && (cnt_eff < total_r);
    pre_wrap  = CNT_CFG_W'(ch_eff) >= n_eff;
    ch_use    = pre_wrap ? '0 : ch_eff;
    frame_use = frame_eff + FRAME_W'(pre_wrap);
    ch_inc    = {1'b0, ch_use} + (CH_W+1)'(1);
    post_wrap = CNT_CFG_W'(ch_inc) >= n_eff;
    last      = (cnt_eff + TOTAL_W'(1)) == total_r;

    push          = accept && want;
    item.clr      = clr_pend_r || start_record;
    item.raw      = raw;
    item.ch       = ch_use;
    item.frame    = frame_use;
    item.last     = last;
    item.partial  = last && (CNT_CFG_W'(ch_inc) != n_eff);
  end

  always_comb begin
    phase_nxt    = phase_r;
    lo_nxt       = lo_r;
    mid_nxt      = mid_r;
    cnt_nxt      = cnt_r;
    ch_nxt       = ch_r;
    frame_nxt    = frame_r;
    clr_pend_nxt = clr_pend_r;
    if (accept) begin
      cnt_nxt   = cnt_eff;
      ch_nxt    = ch_eff;
      frame_nxt = frame_eff;
      unique case (phase_eff)
        PH_LOW: begin
          lo_nxt    = byte_in;
          phase_nxt = PH_MID;
        end
        PH_MID: begin
          mid_nxt   = byte_in;
          phase_nxt = PH_HIGH;
        end
        PH_HIGH: begin
          phase_nxt = PH_LOW;
        end
        default: begin
          phase_nxt = PH_LOW;
        end
      endcase
      if (want) begin
        cnt_nxt      = cnt_eff + TOTAL_W'(1);
        ch_nxt       = post_wrap ? '0 : ch_inc[CH_W-1:0];
        frame_nxt    = frame_use + FRAME_W'(post_wrap);
        clr_pend_nxt = 1'b0;
      end else if (start_record) begin
        clr_pend_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chan_cnt_r <= CNT_CFG_W'(1);
      total_r    <= '0;
      phase_r    <= PH_LOW;
      lo_r       <= '0;
      mid_r      <= '0;
      cnt_r      <= '0;
      ch_r       <= '0;
      frame_r    <= '0;
      clr_pend_r <= 1'b0;
    end else begin
      if (cfg_we && (cfg_index == CFG_CHANNEL_COUNT)) begin
        chan_cnt_r <= cfg_wdata[CNT_CFG_W-1:0];
      end
      if (cfg_we && (cfg_index == CFG_TOTAL_SAMPLES)) begin
        total_r <= cfg_wdata[TOTAL_W-1:0];
      end
      phase_r    <= phase_nxt;
      lo_r       <= lo_nxt;
      mid_r      <= mid_nxt;
      cnt_r      <= cnt_nxt;
      ch_r       <= ch_nxt;
      frame_r    <= frame_nxt;
      clr_pend_r <= clr_pend_nxt;
    end
  end

endmodule

FILE: hdl/p12d_queue.sv
// Two-entry queue of classified sample items between front and back.
// Depends on p12d_pkg.
module p12d_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  p12d_pkg::item_t push_item,
  input  logic            pop,
  output logic            not_full,
  output logic            not_empty,
  output p12d_pkg::item_t head
);
  import p12d_pkg::*;

  item_t             mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   count_r, count_nxt;

  assign not_full  = count_r != (QPTR_W+1)'(QUEUE_DEPTH);
  assign not_empty = count_r != '0;
  assign head      = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

FILE: hdl/p12d_back.sv
// Back end: per-channel checksum accumulation and the result output register.
// Depends on p12d_pkg.
module p12d_back (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 head_valid,
  input  p12d_pkg::item_t                      head,
  output logic                                 pop,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [p12d_pkg::SAMPLE_W-1:0] out_sample_value,
  output logic [p12d_pkg::CH_W-1:0]            out_channel_index,
  output logic [p12d_pkg::FRAME_W-1:0]         out_frame_index,
  output logic signed [p12d_pkg::SUM_W-1:0]    out_channel_checksum,
  output logic                                 out_last_sample,
  output logic                                 out_partial_frame
);
  import p12d_pkg::*;

  logic [SUM_W-1:0]        sum_r [MAX_CHANNELS];
  logic [MAX_CHANNELS-1:0] vld_r, vld_nxt;
  logic                    ov_r, ov_nxt;
  logic [SUM_W-1:0]        base, ext, sum;
  item_t                   res_r;
  logic [SUM_W-1:0]        res_sum_r;

  always_comb begin
    pop  = head_valid && (!ov_r || out_ready);
    base = (head.clr || !vld_r[head.ch]) ? '0 : sum_r[head.ch];
    ext  = {{(SUM_W-SAMPLE_W){head.raw[SAMPLE_W-1]}}, head.raw};
    sum  = base + ext;

    vld_nxt = vld_r;
    if (pop) begin
      if (head.clr) begin
        vld_nxt = '0;
      end
      vld_nxt[head.ch] = 1'b1;
    end

    ov_nxt = ov_r;
    if (pop) begin
      ov_nxt = 1'b1;
    end else if (out_ready) begin
      ov_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      sum_r[head.ch] <= sum;
      res_r          <= head;
      res_sum_r      <= sum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      ov_r  <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
      ov_r  <= ov_nxt;
    end
  end

  assign out_valid            = ov_r;
  assign out_sample_value     = res_r.raw;
  assign out_channel_index    = res_r.ch;
  assign out_frame_index      = res_r.frame;
  assign out_channel_checksum = res_sum_r;
  assign out_last_sample      = res_r.last;
  assign out_partial_frame    = res_r.partial;

endmodule

FILE: hdl/packed_12bit_sample_deinterleaver.sv
// Top level of the packed 12-bit sample deinterleaver.
// Instantiates p12d_front, p12d_queue and p12d_back; depends on p12d_pkg.
//
// The block takes one byte per cycle while in_ready is high and gives one
// sample for the second and third byte of each three-byte group, tagged with
// channel, frame and the channel's running 16-bit checksum. A sample is
// registered into the two-entry queue when its byte is accepted, then into
// the checksum stage's output register by a single read-modify-write of the
// per-channel sum. Configuration writes take effect on the next byte and do
// not clear decoding state; only a byte with start_record or reset does.
module packed_12bit_sample_deinterleaver (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [p12d_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [p12d_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_start_record,
  input  logic [7:0]                           in_byte_in,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [p12d_pkg::SAMPLE_W-1:0] out_sample_value,
  output logic [p12d_pkg::CH_W-1:0]            out_channel_index,
  output logic [p12d_pkg::FRAME_W-1:0]         out_frame_index,
  output logic signed [p12d_pkg::SUM_W-1:0]    out_channel_checksum,
  output logic                                 out_last_sample,
  output logic                                 out_partial_frame
);
  import p12d_pkg::*;

  logic  push, pop, q_not_full, q_not_empty, accept;
  item_t push_item, head;

  assign in_ready = q_not_full;
  assign accept   = in_valid && q_not_full;

  p12d_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .accept       (accept),
    .start_record (in_start_record),
    .byte_in      (in_byte_in),
    .push         (push),
    .item         (push_item)
  );

  p12d_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .not_full  (q_not_full),
    .not_empty (q_not_empty),
    .head      (head)
  );

  p12d_back u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .head_valid           (q_not_empty),
    .head                 (head),
    .pop                  (pop),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_sample_value     (out_sample_value),
    .out_channel_index    (out_channel_index),
    .out_frame_index      (out_frame_index),
    .out_channel_checksum (out_channel_checksum),
    .out_last_sample      (out_last_sample),
    .out_partial_frame    (out_partial_frame)
  );

endmodule

FILE: tb/p12d_sample_checker.sv
`timescale 1ns / 100ps
// Checker for packed_12bit_sample_deinterleaver. It follows register writes and
// byte beats, predicts each decoded sample and compares every output beat with it.
// Depends on p12d_pkg for widths, register indexes and the byte phase encoding.
module p12d_sample_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [p12d_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [p12d_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  logic                            in_start_record,
  input  logic [7:0]                      in_byte_in,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  logic [p12d_pkg::SAMPLE_W-1:0]   out_sample_value,
  input  logic [p12d_pkg::CH_W-1:0]       out_channel_index,
  input  logic [p12d_pkg::FRAME_W-1:0]    out_frame_index,
  input  logic [p12d_pkg::SUM_W-1:0]      out_channel_checksum,
  input  logic                            out_last_sample,
  input  logic                            out_partial_frame,
  output int                              mismatches,
  output int                              outstanding,
  output int                              samples_checked
);
  import p12d_pkg::*;

  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [SAMPLE_W-1:0] value;
    logic [CH_W-1:0]     chan;
    logic [FRAME_W-1:0]  frame;
    logic [SUM_W-1:0]    sum;
    logic                last;
    logic                partial;
  } sample_t;

  logic [CNT_CFG_W-1:0] chan_cfg;
  logic [TOTAL_W-1:0]   total_cfg;
  phase_t               phase;
  logic [7:0]           lo_held;
  logic [7:0]           mid_byte;
  logic [TOTAL_W-1:0]   emitted;
  logic [CH_W:0]        cur_chan;
  logic [FRAME_W-1:0]   cur_frame;
  logic [SUM_W-1:0]     sums [MAX_CHANNELS];
  sample_t              expected_samples [$];

  task automatic clear_record();
    phase     = PH_LOW;
    lo_held   = '0;
    mid_byte  = '0;
    emitted   = '0;
    cur_chan  = '0;
    cur_frame = '0;
    foreach (sums[i]) sums[i] = '0;
  endtask

  task automatic take_sample(input logic [SAMPLE_W-1:0] raw);
    logic [CH_W:0] span;
    sample_t       s;
    if (emitted >= total_cfg) return;
    if (chan_cfg == '0) span = (CH_W+1)'(1);
    else if (chan_cfg > CNT_CFG_W'(MAX_CHANNELS)) span = (CH_W+1)'(MAX_CHANNELS);
    else span = chan_cfg;
    if (cur_chan >= span) begin
      cur_chan = '0;
      cur_frame++;
    end
    sums[cur_chan[CH_W-1:0]] += {{(SUM_W-SAMPLE_W){raw[SAMPLE_W-1]}}, raw};
    s.value   = raw;
    s.chan    = cur_chan[CH_W-1:0];
    s.frame   = cur_frame;
    s.sum     = sums[cur_chan[CH_W-1:0]];
    s.last    = (emitted + 1'b1) == total_cfg;
    s.partial = s.last && ((cur_chan + 1'b1) != span);
    expected_samples.insert(expected_samples.size(), s);
    emitted++;
    cur_chan++;
    if (cur_chan >= span) begin
      cur_chan = '0;
      cur_frame++;
    end
  endtask

  task automatic unpack_byte(input logic start, input logic [7:0] b);
    if (start) clear_record();
    case (phase)
      PH_LOW: begin
        lo_held = b;
        phase = PH_MID;
      end
      PH_MID: begin
        mid_byte = b;
        take_sample({b[3:0], lo_held});
        phase = PH_HIGH;
      end
      default: begin
        take_sample({mid_byte[7:4], b});
        phase = PH_LOW;
      end
    endcase
  endtask

  task automatic compare_beat();
    sample_t want;
    if (expected_samples.size() == 0) begin
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
        $display("%0t: unexpected sample value %0d chan %0d frame %0d", $realtime,
                 $signed(out_sample_value), out_channel_index, out_frame_index);
      return;
    end
    want = expected_samples.pop_front();
    samples_checked++;
    if (out_sample_value !== want.value || out_channel_index !== want.chan ||
        out_frame_index !== want.frame || out_channel_checksum !== want.sum ||
        out_last_sample !== want.last || out_partial_frame !== want.partial) begin
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
        $display({"%0t: sample mismatch (expected/actual) value %0d/%0d chan %0d/%0d",
                  " frame %0d/%0d sum %0d/%0d last %b/%b partial %b/%b"}, $realtime,
                 $signed(want.value), $signed(out_sample_value),
                 want.chan, out_channel_index, want.frame, out_frame_index,
                 $signed(want.sum), $signed(out_channel_checksum),
                 want.last, out_last_sample, want.partial, out_partial_frame);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      chan_cfg        = CNT_CFG_W'(1);
      total_cfg       = '0;
      mismatches      = 0;
      samples_checked = 0;
      clear_record();
      expected_samples.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_CHANNEL_COUNT: chan_cfg = cfg_wdata[CNT_CFG_W-1:0];
          CFG_TOTAL_SAMPLES: total_cfg = cfg_wdata[TOTAL_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) unpack_byte(in_start_record, in_byte_in);
      if (out_valid && out_ready) compare_beat();
    end
    outstanding = expected_samples.size();
  end

endmodule

FILE: tb/packed_12bit_sample_deinterleaver_tb.sv
`timescale 1ns / 100ps
// Testbench top for packed_12bit_sample_deinterleaver: directed records with a long
// output hold-off, then random format-212 records under four flow-control mixes.
// Depends on p12d_pkg, the block's RTL and p12d_sample_checker.
module packed_12bit_sample_deinterleaver_tb;
  import p12d_pkg::*;

  localparam int RANDOM_BYTES  = 1200;
  localparam int HOLD_CYCLES   = 200;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_LIMIT   = 20000;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

  typedef enum logic [1:0] {
    FLOW_FREE,
    FLOW_SLOW_SOURCE,
    FLOW_SLOW_SINK,
    FLOW_BOTH_SLOW
  } flow_t;

  logic                         clk;
  logic                         rst_n;
  logic                         cfg_we;
  logic [CFG_IDX_W-1:0]         cfg_index;
  logic [CFG_DATA_W-1:0]        cfg_wdata;
  logic                         in_valid;
  logic                         in_ready;
  logic                         in_start_record;
  logic [7:0]                   in_byte_in;
  logic                         out_valid;
  logic                         out_ready;
  logic signed [SAMPLE_W-1:0]   out_sample_value;
  logic [CH_W-1:0]              out_channel_index;
  logic [FRAME_W-1:0]           out_frame_index;
  logic signed [SUM_W-1:0]      out_channel_checksum;
  logic                         out_last_sample;
  logic                         out_partial_frame;
  int                           mismatches;
  int                           outstanding;
  int                           samples_checked;
  flow_t                        flow = FLOW_FREE;
  logic                         hold_request = 1'b0;
  int                           bytes_sent;
  int                           records_sent;

  packed_12bit_sample_deinterleaver uut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_start_record      (in_start_record),
    .in_byte_in           (in_byte_in),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_sample_value     (out_sample_value),
    .out_channel_index    (out_channel_index),
    .out_frame_index      (out_frame_index),
    .out_channel_checksum (out_channel_checksum),
    .out_last_sample      (out_last_sample),
    .out_partial_frame    (out_partial_frame)
  );

  p12d_sample_checker u_checker (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_start_record      (in_start_record),
    .in_byte_in           (in_byte_in),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_sample_value     (out_sample_value),
    .out_channel_index    (out_channel_index),
    .out_frame_index      (out_frame_index),
    .out_channel_checksum (out_channel_checksum),
    .out_last_sample      (out_last_sample),
    .out_partial_frame    (out_partial_frame),
    .mismatches           (mismatches),
    .outstanding          (outstanding),
    .samples_checked      (samples_checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic bit idle_now(input bit sink_side);
    int pct;
    case (flow)
      FLOW_SLOW_SOURCE: pct = sink_side ? 0 : 87;
      FLOW_SLOW_SINK:   pct = sink_side ? 87 : 0;
      FLOW_BOTH_SLOW:   pct = 15;
      default:          pct = 0;
    endcase
    return $urandom_range(99) < pct;
  endfunction

  function automatic logic [7:0] pick_byte(input bit loud);
    if (!loud) return 8'($urandom);
    case ($urandom_range(5))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h80;
      3: return 8'h7F;
      4: return 8'h08;
      default: return 8'hF7;
    endcase
  endfunction

  // The long hold-off is timed here so that the sender keeps offering beats meanwhile.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        out_ready <= !idle_now(1'b1);
      end
    end
  end

  task automatic send_byte(input logic start, input logic [7:0] data);
    while (idle_now(1'b0)) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_start_record <= start;
    in_byte_in      <= data;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    bytes_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic settle();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    while (outstanding != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin
    logic [CNT_CFG_W-1:0] count;
    logic [TOTAL_W-1:0]   total;
    int                   needed;
    int                   extra;
    int                   useful_sent;
    bit                   opener;
    bit                   loud;

    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = CFG_CHANNEL_COUNT;
    cfg_wdata       = '0;
    in_valid        = 1'b0;
    in_start_record = 1'b0;
    in_byte_in      = '0;
    bytes_sent      = 0;
    records_sent    = 0;
    useful_sent     = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Two channels, odd total: padding sample dropped, then one byte past the count.
    write_reg(CFG_CHANNEL_COUNT, 32'hFFFF_FFE2);
    write_reg(CFG_TOTAL_SAMPLES, 32'd5);
    write_reg(CFG_SPARE_2, '1);
    write_reg(CFG_SPARE_3, 32'd7);
    send_byte(1'b1, 8'hFF);
    send_byte(1'b0, 8'hFF);
    send_byte(1'b0, 8'hFF);
    send_byte(1'b0, 8'hFF);
    send_byte(1'b0, 8'h87);
    send_byte(1'b0, 8'h00);
    send_byte(1'b0, 8'h00);
    send_byte(1'b0, 8'h00);
    send_byte(1'b0, 8'h00);
    send_byte(1'b0, 8'h5A);
    settle();

    // Zero channel count and zero total: nothing comes out.
    write_reg(CFG_CHANNEL_COUNT, '0);
    write_reg(CFG_TOTAL_SAMPLES, '0);
    send_byte(1'b1, 8'h12);
    send_byte(1'b0, 8'h34);
    send_byte(1'b0, 8'h56);
    settle();

    // Channel count lowered below the current channel in the middle of a record.
    write_reg(CFG_CHANNEL_COUNT, 32'd4);
    write_reg(CFG_TOTAL_SAMPLES, 32'd6);
    send_byte(1'b1, 8'h11);
    send_byte(1'b0, 8'hF2);
    send_byte(1'b0, 8'h33);
    send_byte(1'b0, 8'h44);
    send_byte(1'b0, 8'hA5);
    settle();
    write_reg(CFG_CHANNEL_COUNT, 32'd2);
    send_byte(1'b0, 8'h66);
    send_byte(1'b0, 8'h77);
    send_byte(1'b0, 8'h08);
    settle();

    // Channel count above the maximum; the record ends in a partial frame.
    write_reg(CFG_CHANNEL_COUNT, 32'd31);
    write_reg(CFG_TOTAL_SAMPLES, 32'd2);
    send_byte(1'b1, 8'h80);
    send_byte(1'b0, 8'h08);
    send_byte(1'b0, 8'h7F);
    settle();

    // Full-scale negative samples on one channel wrap the checksum while the
    // output is held off long enough to back the block up.
    write_reg(CFG_CHANNEL_COUNT, 32'd1);
    write_reg(CFG_TOTAL_SAMPLES, 32'd40);
    hold_request = 1'b1;
    for (int i = 0; i < 60; i++) begin
      send_byte(i == 0, (i % 3 == 1) ? 8'h88 : 8'h00);
      useful_sent++;
    end
    settle();

    while (useful_sent < RANDOM_BYTES) begin
      flow = flow_t'(records_sent % 4);
      case ($urandom_range(9))
        0:       count = '0;
        1:       count = 5'($urandom_range(31, 17));
        default: count = 5'($urandom_range(16, 1));
      endcase
      case ($urandom_range(19))
        0:       total = '0;
        1:       total = '1;
        2, 3:    total = $urandom_range(120, 41);
        default: total = $urandom_range(40, 1);
      endcase
      if (total == '1) needed = $urandom_range(60, 10);
      else needed = ((total + 1) / 2) * 3;
      extra  = ($urandom_range(3) == 0) ? $urandom_range(4, 1) : 0;
      opener = $urandom_range(9) != 0;
      loud   = $urandom_range(3) == 0;
      settle();
      write_reg(CFG_CHANNEL_COUNT, {27'($urandom), count});
      write_reg(CFG_TOTAL_SAMPLES, total);
      for (int i = 0; i < needed + extra; i++) begin
        send_byte((i == 0 && opener) || $urandom_range(63) == 0, pick_byte(loud));
        if (i < needed) useful_sent++;
      end
      records_sent++;
    end
    settle();

    $display("Sent %0d bytes in %0d random records plus directed ones; %0d samples checked.",
             bytes_sent, records_sent, samples_checked);
    $display("Covered odd totals, bytes past the count, odd channel counts and back-pressure.");
    if (mismatches == 0 && outstanding == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      if (outstanding != 0) $display("%0d expected samples never appeared", outstanding);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
